FILE: sv/pressure_sensor_compensation_core_macros.svh
// Assertion macros shared by the pressure compensation RTL.
`ifndef PRESSURE_SENSOR_COMPENSATION_CORE_MACROS_SVH
`define PRESSURE_SENSOR_COMPENSATION_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSCC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/pscc_pkg.sv
// Shared widths, codes, control types and helpers for the pressure compensation core.
package pscc_pkg;

    localparam int W_RAW      = 24;
    localparam int W_COEF     = 16;
    localparam int W_TEMP     = 19;
    localparam int W_PRES     = 32;
    localparam int W_CFG_IDX  = 3;
    localparam int W_DT       = 25;
    localparam int W_SQ       = 20;
    localparam int W_MA       = 25;
    localparam int W_MB       = 22;
    localparam int W_PROD     = W_MA + W_MB;
    localparam int W_ACC      = 42;
    localparam int W_Q        = 45;
    localparam int SENS_SPLIT = 21;

    localparam logic [W_CFG_IDX-1:0] CFG_SENS     = 3'd0;
    localparam logic [W_CFG_IDX-1:0] CFG_OFF      = 3'd1;
    localparam logic [W_CFG_IDX-1:0] CFG_TCS      = 3'd2;
    localparam logic [W_CFG_IDX-1:0] CFG_TCO      = 3'd3;
    localparam logic [W_CFG_IDX-1:0] CFG_TREF     = 3'd4;
    localparam logic [W_CFG_IDX-1:0] CFG_TEMPSENS = 3'd5;

    localparam logic signed [W_TEMP-1:0] TEMP_REF  = 19'sd2000;
    localparam logic signed [W_TEMP-1:0] TEMP_VLOW = -19'sd1500;

    localparam logic signed [W_Q-1:0] P_MAX = W_Q'(64'sd2147483647);
    localparam logic signed [W_Q-1:0] P_MIN = W_Q'(-64'sd2147483648);

    // Operand pairs that the shared multiplier can be given.
    typedef enum logic [2:0] {
        OP_TEMP,
        OP_OFF,
        OP_SENS,
        OP_D,
        OP_E11,
        OP_E7,
        OP_LO,
        OP_HI
    } t_op;

    typedef struct packed {
        t_op  op;
        logic ready;
        logic ld_dt;
        logic ld_temp;
        logic ld_off;
        logic ld_sq;
        logic ld_sens;
        logic fix_sq;
        logic fix_e11;
        logic fix_e7;
        logic ld_acc;
        logic ld_q;
        logic ld_x;
        logic ld_p;
        logic ld_out;
    } t_ctl;

    // Arithmetic right shift that rounds toward zero instead of toward minus infinity.
    function automatic logic signed [W_PROD-1:0] sra_trunc(
        input logic signed [W_PROD-1:0] x,
        input int unsigned              k
    );
        logic signed [W_PROD-1:0] bias;
        bias = '0;
        if (x[W_PROD-1]) begin
            bias = ~({W_PROD{1'b1}} << k);
        end
        return (x + bias) >>> k;
    endfunction

endpackage

FILE: sv/pscc_in_if.sv
// Input channel carrying raw conversion results.
interface pscc_in_if;
    import pscc_pkg::*;

    logic              valid;
    logic              ready;
    logic [W_RAW-1:0]  raw_value;
    logic              is_pressure;

    modport source (output valid, output raw_value, output is_pressure, input ready);
    modport sink   (input valid, input raw_value, input is_pressure, output ready);
endinterface

FILE: sv/pscc_out_if.sv
// Output channel carrying compensated temperature and pressure.
interface pscc_out_if;
    import pscc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [W_TEMP-1:0] temperature;
    logic signed [W_PRES-1:0] pressure;

    modport source (output valid, output temperature, output pressure, input ready);
    modport sink   (input valid, input temperature, input pressure, output ready);
endinterface

FILE: sv/pscc_mul.sv
// Shared signed multiplier with a registered product.
module pscc_mul (
    input  logic                                i_clk,
    input  logic signed [pscc_pkg::W_MA-1:0]    i_a,
    input  logic signed [pscc_pkg::W_MB-1:0]    i_b,
    output logic signed [pscc_pkg::W_PROD-1:0]  o_prod
);
    import pscc_pkg::*;

    logic signed [W_PROD-1:0] r_prod;

    // Both operands are sign-extended to the full product width before the multiply.
    always_ff @(posedge i_clk) begin
        r_prod <= W_PROD'(i_a) * W_PROD'(i_b);
    end

    assign o_prod = r_prod;
endmodule

FILE: sv/pscc_seq.sv
// Sequencer that steps one reading through the shared multiplier and the compensation steps.
module pscc_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_fire,
    input  logic            i_out_free,
    output pscc_pkg::t_ctl  o_ctl
);
    import pscc_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001,
        S_DT   = 14'b00000000000010,
        S_MT   = 14'b00000000000100,
        S_MO   = 14'b00000000001000,
        S_MS   = 14'b00000000010000,
        S_MD   = 14'b00000000100000,
        S_ME   = 14'b00000001000000,
        S_MF   = 14'b00000010000000,
        S_MG   = 14'b00000100000000,
        S_PH   = 14'b00001000000000,
        S_PQ   = 14'b00010000000000,
        S_PS   = 14'b00100000000000,
        S_PD   = 14'b01000000000000,
        S_SAT  = 14'b10000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state   = r_state;
        o_ctl     = '0;
        o_ctl.op  = OP_TEMP;
        case (r_state)
            S_IDLE: begin
                o_ctl.ready = 1'b1;
                if (i_in_fire) begin
                    n_state = S_DT;
                end
            end
            S_DT: begin
                o_ctl.ld_dt = 1'b1;
                n_state     = S_MT;
            end
            S_MT: begin
                o_ctl.op = OP_TEMP;
                n_state  = S_MO;
            end
            S_MO: begin
                o_ctl.ld_temp = 1'b1;
                o_ctl.op      = OP_OFF;
                n_state       = S_MS;
            end
            S_MS: begin
                o_ctl.ld_off = 1'b1;
                o_ctl.ld_sq  = 1'b1;
                o_ctl.op     = OP_SENS;
                n_state      = S_MD;
            end
            S_MD: begin
                o_ctl.ld_sens = 1'b1;
                o_ctl.op      = OP_D;
                n_state       = S_ME;
            end
            S_ME: begin
                o_ctl.fix_sq = 1'b1;
                o_ctl.op     = OP_E11;
                n_state      = S_MF;
            end
            S_MF: begin
                o_ctl.fix_e11 = 1'b1;
                o_ctl.op      = OP_E7;
                n_state       = S_MG;
            end
            S_MG: begin
                o_ctl.fix_e7 = 1'b1;
                o_ctl.op     = OP_LO;
                n_state      = S_PH;
            end
            S_PH: begin
                o_ctl.ld_acc = 1'b1;
                o_ctl.op     = OP_HI;
                n_state      = S_PQ;
            end
            S_PQ: begin
                o_ctl.ld_q = 1'b1;
                n_state    = S_PS;
            end
            S_PS: begin
                o_ctl.ld_x = 1'b1;
                n_state    = S_PD;
            end
            S_PD: begin
                o_ctl.ld_p = 1'b1;
                n_state    = S_SAT;
            end
            S_SAT: begin
                // Hold the finished result here until the output register frees up.
                if (i_out_free) begin
                    o_ctl.ld_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

FILE: sv/pressure_sensor_compensation_core.sv
// Top level of the pressure and temperature compensation core.
//
// Raw 24-bit conversion beats arrive on i_raw, each flagged as a temperature
// or a pressure reading; the block keeps the latest reading of each kind and
// returns one beat on o_comp per input beat, holding the compensated
// temperature (0.01 C) and the saturated pressure (0.01 mbar).
// Calibration words C1..C6 are written through i_cfg_we, i_cfg_idx and
// i_cfg_data; the user must write them only while the block is idle, which
// the block itself does not enforce; indexes above five are ignored.
// The sequencer routes every product through one registered 25 x 22 bit
// multiplier, eight products per beat, plus the post steps, and accepts no
// new beat until it is back in idle.
// The output register lets one further beat be accepted while a result waits;
// if the receiver still stalls, that beat's result is held in the final step
// and input ready stays low until the output register is taken.
// Reset clears the calibration words and both stored readings to zero,
// returns the sequencer to idle and drops any pending result.
`include "pressure_sensor_compensation_core_macros.svh"

module pressure_sensor_compensation_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    pscc_in_if.sink                            i_raw,
    pscc_out_if.source                         o_comp,
    input  logic                               i_cfg_we,
    input  logic [pscc_pkg::W_CFG_IDX-1:0]     i_cfg_idx,
    input  logic [pscc_pkg::W_COEF-1:0]        i_cfg_data
);
    import pscc_pkg::*;

    logic [W_COEF-1:0] r_c1, r_c2, r_c3, r_c4, r_c5, r_c6;
    logic [W_RAW-1:0]  r_raw_t, r_raw_p;

    logic signed [W_DT-1:0]   r_dt;
    logic signed [W_TEMP-1:0] r_temp;
    logic signed [W_ACC-1:0]  r_off, r_sens;
    logic signed [W_SQ-1:0]   r_d;
    logic signed [W_MB-1:0]   r_d5, r_e7, r_e11;
    logic                     r_low, r_vlow;
    logic signed [W_Q-1:0]    r_acc, r_q, r_x, r_p;
    logic                     r_rnz;

    logic                     r_out_valid;
    logic signed [W_TEMP-1:0] r_temp_out;
    logic signed [W_PRES-1:0] r_pres_out;

    t_ctl ctl;
    logic in_fire;
    logic out_free;

    logic signed [W_MA-1:0]   mul_a;
    logic signed [W_MB-1:0]   mul_b;
    logic signed [W_PROD-1:0] prod;

    logic signed [W_DT-1:0]   n_dt;
    logic signed [W_TEMP-1:0] n_temp;
    logic signed [W_ACC-1:0]  n_off, n_sens;
    logic signed [W_SQ-1:0]   n_d, n_e;
    logic signed [W_Q-1:0]    n_x, n_pres;

    assign in_fire     = i_raw.valid && ctl.ready;
    assign out_free    = !r_out_valid || o_comp.ready;
    assign i_raw.ready = ctl.ready;

    assign o_comp.valid       = r_out_valid;
    assign o_comp.temperature = r_temp_out;
    assign o_comp.pressure    = r_pres_out;

    pscc_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (in_fire),
        .i_out_free (out_free),
        .o_ctl      (ctl)
    );

    pscc_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    always_comb begin
        case (ctl.op)
            OP_TEMP: begin
                mul_a = r_dt;
                mul_b = {{(W_MB-W_COEF){1'b0}}, r_c6};
            end
            OP_OFF: begin
                mul_a = r_dt;
                mul_b = {{(W_MB-W_COEF){1'b0}}, r_c4};
            end
            OP_SENS: begin
                mul_a = r_dt;
                mul_b = {{(W_MB-W_COEF){1'b0}}, r_c3};
            end
            OP_D: begin
                mul_a = W_MA'(r_d);
                mul_b = r_d5;
            end
            OP_E11: begin
                mul_a = W_MA'(n_e);
                mul_b = r_e11;
            end
            OP_E7: begin
                mul_a = W_MA'(n_e);
                mul_b = r_e7;
            end
            // Pressure product is split: low part unsigned, high part signed.
            OP_LO: begin
                mul_a = {{(W_MA-W_RAW){1'b0}}, r_raw_p};
                mul_b = {{(W_MB-SENS_SPLIT){1'b0}}, r_sens[SENS_SPLIT-1:0]};
            end
            OP_HI: begin
                mul_a = {{(W_MA-W_RAW){1'b0}}, r_raw_p};
                mul_b = W_MB'(signed'(r_sens[W_ACC-1:SENS_SPLIT]));
            end
            default: begin
                mul_a = r_dt;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        n_dt   = W_DT'({1'b0, r_raw_t}) - W_DT'({r_c5, 8'h00});
        n_temp = TEMP_REF + W_TEMP'(sra_trunc(prod, 23));
        n_off  = W_ACC'({r_c2, 16'h0000}) + W_ACC'(sra_trunc(prod, 7));
        n_sens = W_ACC'({r_c1, 15'h0000}) + W_ACC'(sra_trunc(prod, 8));
        n_d    = W_SQ'(r_temp) - W_SQ'(TEMP_REF);
        n_e    = W_SQ'(r_temp) - W_SQ'(TEMP_VLOW);
        // The floor quotient of the pressure product is bumped by one when it is
        // negative with a nonzero remainder, which gives truncation toward zero.
        n_x    = r_q - W_Q'(r_off) + ((r_q[W_Q-1] && r_rnz) ? W_Q'(1) : W_Q'(0));
        n_pres = W_Q'(sra_trunc(W_PROD'(r_x), 15));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1    <= '0;
            r_c2    <= '0;
            r_c3    <= '0;
            r_c4    <= '0;
            r_c5    <= '0;
            r_c6    <= '0;
            r_raw_t <= '0;
            r_raw_p <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SENS:     r_c1 <= i_cfg_data;
                    CFG_OFF:      r_c2 <= i_cfg_data;
                    CFG_TCS:      r_c3 <= i_cfg_data;
                    CFG_TCO:      r_c4 <= i_cfg_data;
                    CFG_TREF:     r_c5 <= i_cfg_data;
                    CFG_TEMPSENS: r_c6 <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (in_fire) begin
                if (i_raw.is_pressure) begin
                    r_raw_p <= i_raw.raw_value;
                end else begin
                    r_raw_t <= i_raw.raw_value;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.ld_dt) begin
            r_dt <= n_dt;
        end
        if (ctl.ld_temp) begin
            r_temp <= n_temp;
        end
        if (ctl.ld_sq) begin
            r_d    <= n_d;
            r_d5   <= (W_MB'(n_d) <<< 2) + W_MB'(n_d);
            r_e11  <= (W_MB'(n_e) <<< 3) + (W_MB'(n_e) <<< 1) + W_MB'(n_e);
            r_e7   <= (W_MB'(n_e) <<< 3) - W_MB'(n_e);
            r_low  <= r_temp < TEMP_REF;
            r_vlow <= r_temp < TEMP_VLOW;
        end
        // The squared terms are never negative, so plain shifts give their quotients.
        if (ctl.ld_off) begin
            r_off <= n_off;
        end else if (ctl.fix_sq && r_low) begin
            r_off <= r_off - W_ACC'(prod >>> 1);
        end else if (ctl.fix_e7 && r_vlow) begin
            r_off <= r_off - W_ACC'(prod);
        end
        if (ctl.ld_sens) begin
            r_sens <= n_sens;
        end else if (ctl.fix_sq && r_low) begin
            r_sens <= r_sens - W_ACC'(prod >>> 2);
        end else if (ctl.fix_e11 && r_vlow) begin
            r_sens <= r_sens - W_ACC'(prod >>> 1);
        end
        if (ctl.ld_acc) begin
            r_acc <= W_Q'(prod >>> SENS_SPLIT);
            r_rnz <= |prod[SENS_SPLIT-1:0];
        end
        if (ctl.ld_q) begin
            r_q <= W_Q'(prod) + r_acc;
        end
        if (ctl.ld_x) begin
            r_x <= n_x;
        end
        if (ctl.ld_p) begin
            r_p <= n_pres;
        end
        if (ctl.ld_out) begin
            r_temp_out <= r_temp;
            if (r_p > P_MAX) begin
                r_pres_out <= W_PRES'(P_MAX);
            end else if (r_p < P_MIN) begin
                r_pres_out <= W_PRES'(P_MIN);
            end else begin
                r_pres_out <= W_PRES'(r_p);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.ld_out) begin
            r_out_valid <= 1'b1;
        end else if (o_comp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    `PSCC_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_fire, !ctl.ready, "ready stayed high after an accepted beat")
    `PSCC_ASSERT_SAME(a_no_overwrite, i_clk, i_rst_n, ctl.ld_out, out_free, "result loaded over a beat not yet taken")
    `PSCC_ASSERT_NEXT(a_vlow_implies_low, i_clk, i_rst_n, ctl.ld_sq, (!r_vlow || r_low), "very low temperature flag set without low flag")
endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the pressure and temperature compensation core.
`timescale 1ns / 1ps

module testbench;
    import pscc_pkg::*;

    localparam logic [W_CFG_IDX-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [W_CFG_IDX-1:0] CFG_SPARE_HI = 3'd7;
    localparam longint PRES_MAX = 64'sd2147483647;
    localparam longint PRES_MIN = -64'sd2147483648;

    typedef struct packed {
        logic signed [W_TEMP-1:0] temperature;
        logic signed [W_PRES-1:0] pressure;
    } t_comp_result;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [W_CFG_IDX-1:0] i_cfg_idx;
    logic [W_COEF-1:0] i_cfg_data;
    logic take_ready = 1'b0;

    pscc_in_if  raw_bus ();
    pscc_out_if comp_bus ();

    assign comp_bus.ready = take_ready;

    pressure_sensor_compensation_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_raw      (raw_bus),
        .o_comp     (comp_bus),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Calibration words and latest readings as the block should hold them.
    logic [W_COEF-1:0] cal [0:5];
    logic [W_RAW-1:0] held_temp_raw;
    logic [W_RAW-1:0] held_pres_raw;

    t_comp_result awaited[$];
    t_comp_result head;

    int src_gap_pct = 0;
    int sink_stall_pct = 0;
    int n_errors = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_cal_sets = 0;
    int n_low = 0;
    int n_vlow = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic void report_error(input string msg);
        if (n_errors < 10) begin
            $display("ERROR at %0t: %s", $realtime, msg);
        end
        n_errors++;
    endfunction

    function automatic t_comp_result compensate();
        longint dt, t, off, sens, off2, sens2, d, e, p;
        t_comp_result r;
        dt   = longint'(held_temp_raw) - longint'(cal[CFG_TREF]) * 256;
        t    = 2000 + (dt * longint'(cal[CFG_TEMPSENS])) / 8388608;
        off  = longint'(cal[CFG_OFF]) * 65536 + (longint'(cal[CFG_TCO]) * dt) / 128;
        sens = longint'(cal[CFG_SENS]) * 32768 + (longint'(cal[CFG_TCS]) * dt) / 256;
        off2 = 0;
        sens2 = 0;
        // Second-order corrections below 20.00 C, with an extra term below -15.00 C.
        if (t < 2000) begin
            d = t - 2000;
            off2 = (5 * d * d) / 2;
            sens2 = (5 * d * d) / 4;
        end
        if (t < -1500) begin
            e = t + 1500;
            off2 += 7 * e * e;
            sens2 += (11 * e * e) / 2;
        end
        off -= off2;
        sens -= sens2;
        p = ((longint'(held_pres_raw) * sens) / 2097152 - off) / 32768;
        if (p > PRES_MAX) begin
            p = PRES_MAX;
        end else if (p < PRES_MIN) begin
            p = PRES_MIN;
        end
        r.temperature = W_TEMP'(t);
        r.pressure = W_PRES'(p);
        return r;
    endfunction

    task automatic send_reading(input logic [W_RAW-1:0] raw, input logic is_pres);
        t_comp_result r;
        while ($urandom_range(99, 0) < src_gap_pct) begin
            raw_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        raw_bus.valid <= 1'b1;
        raw_bus.raw_value <= raw;
        raw_bus.is_pressure <= is_pres;
        do @(posedge i_clk); while (!raw_bus.ready);
        if (is_pres) begin
            held_pres_raw = raw;
        end else begin
            held_temp_raw = raw;
        end
        r = compensate();
        awaited.push_back(r);
        n_sent++;
        if (r.temperature < TEMP_REF) n_low++;
        if (r.temperature < TEMP_VLOW) n_vlow++;
    endtask

    // Drops valid and waits until every outstanding result has been taken.
    task automatic wait_idle();
        raw_bus.valid <= 1'b0;
        do @(posedge i_clk); while (awaited.size() != 0);
    endtask

    task automatic cfg_write(input logic [W_CFG_IDX-1:0] idx, input logic [W_COEF-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (idx <= CFG_TEMPSENS) begin
            cal[idx] = data;
        end
    endtask

    task automatic load_calibration(input logic [W_COEF-1:0] c1, c2, c3, c4, c5, c6);
        wait_idle();
        cfg_write(CFG_SENS, c1);
        cfg_write(CFG_OFF, c2);
        cfg_write(CFG_TCS, c3);
        cfg_write(CFG_TCO, c4);
        cfg_write(CFG_TREF, c5);
        cfg_write(CFG_TEMPSENS, c6);
        i_cfg_we <= 1'b0;
        n_cal_sets++;
    endtask

    function automatic logic [W_RAW-1:0] pick_temp_raw();
        int unsigned sel;
        longint v;
        sel = $urandom_range(99, 0);
        v = longint'(cal[CFG_TREF]) * 256;
        if (sel < 40) begin
            v += longint'($urandom_range(8388608, 0)) - 4194304;
        end else if (sel < 55) begin
            v += longint'($urandom_range(2048, 0)) - 1024;
        end else if (sel < 65) begin
            v = $urandom_range(1, 0) ? 0 : 16777215;
        end else begin
            v = longint'($urandom() & 32'h00FF_FFFF);
        end
        if (v < 0) v = 0;
        if (v > 16777215) v = 16777215;
        return W_RAW'(v);
    endfunction

    function automatic logic [W_RAW-1:0] pick_pres_raw();
        int unsigned sel;
        sel = $urandom_range(99, 0);
        if (sel < 50) return W_RAW'($urandom());
        if (sel < 80) return W_RAW'(9000000 + $urandom_range(2097152, 0) - 1048576);
        return $urandom_range(1, 0) ? '0 : '1;
    endfunction

    task automatic test_after_reset();
        // Coefficients are still zero and no temperature has been seen yet.
        send_reading(24'd9085466, 1'b1);
        load_calibration(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
        send_reading(24'd9085466, 1'b1);
        send_reading(24'd8569150, 1'b0);
    endtask

    task automatic test_spare_index();
        wait_idle();
        cfg_write(CFG_SPARE_LO, 16'hFFFF);
        cfg_write(CFG_SPARE_HI, 16'h5A5A);
        i_cfg_we <= 1'b0;
        send_reading(24'd8569150, 1'b0);
        send_reading(24'd9085466, 1'b1);
    endtask

    task automatic test_temperature_thresholds();
        // With C5 = C6 = 2^15 every step of 256 in D2 moves TEMP by one hundredth.
        load_calibration(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd32768, 16'd32768);
        send_reading(24'd8388608, 1'b0);
        send_reading(24'd8388607, 1'b0);
        send_reading(24'd8388352, 1'b0);
        send_reading(24'd7492608, 1'b0);
        send_reading(24'd7492352, 1'b0);
        send_reading(24'hFFFFFF, 1'b1);
    endtask

    task automatic test_field_extremes();
        load_calibration('1, '1, '1, '1, '1, '1);
        send_reading('0, 1'b0);
        send_reading('1, 1'b1);
        send_reading('1, 1'b0);
        send_reading('0, 1'b1);
        // Coldest reachable temperature.
        load_calibration('1, '0, '0, '1, '1, '1);
        send_reading('0, 1'b0);
        send_reading('1, 1'b1);
        // Hottest reachable temperature.
        load_calibration('0, '1, '1, '0, '0, '1);
        send_reading('1, 1'b0);
        send_reading('1, 1'b1);
    endtask

    task automatic test_random_traffic(input int n_items, input logic all_ones);
        int sent;
        sent = 0;
        if (all_ones) begin
            load_calibration('1, '1, '1, '1, '1, '1);
        end else begin
            load_calibration(W_COEF'($urandom()), W_COEF'($urandom()), W_COEF'($urandom()),
                             W_COEF'($urandom()), W_COEF'($urandom()), W_COEF'($urandom()));
        end
        while (sent < n_items) begin
            if ($urandom_range(99, 0) < 70) begin
                send_reading(pick_temp_raw(), 1'b0);
                send_reading(pick_pres_raw(), 1'b1);
                sent += 2;
            end else begin
                if ($urandom_range(1, 0)) begin
                    send_reading(pick_pres_raw(), 1'b1);
                end else begin
                    send_reading(pick_temp_raw(), 1'b0);
                end
                sent++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && comp_bus.valid && comp_bus.ready) begin
            if (awaited.size() == 0) begin
                report_error($sformatf("unexpected result: temperature %0d, pressure %0d",
                                       comp_bus.temperature, comp_bus.pressure));
            end else begin
                head = awaited.pop_front();
                if (comp_bus.temperature !== head.temperature) begin
                    report_error($sformatf("temperature: expected %0d, got %0d",
                                           head.temperature, comp_bus.temperature));
                end
                if (comp_bus.pressure !== head.pressure) begin
                    report_error($sformatf("pressure: expected %0d, got %0d",
                                           head.pressure, comp_bus.pressure));
                end
            end
            n_checked++;
        end
        take_ready <= ($urandom_range(99, 0) >= sink_stall_pct);
    end

    initial begin
        #2000000;
        $display("Timeout with %0d results outstanding", awaited.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= '0;
        i_cfg_data <= '0;
        raw_bus.valid <= 1'b0;
        raw_bus.raw_value <= '0;
        raw_bus.is_pressure <= 1'b0;
        for (int i = CFG_SENS; i <= CFG_TEMPSENS; i++) begin
            cal[i] = '0;
        end
        held_temp_raw = '0;
        held_pres_raw = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_gap_pct = 22;
        sink_stall_pct = 46;
        test_after_reset();
        test_spare_index();
        test_temperature_thresholds();
        test_field_extremes();
        test_random_traffic(180, 1'b0);

        src_gap_pct = 46;
        sink_stall_pct = 22;
        test_random_traffic(180, 1'b0);

        src_gap_pct = 0;
        sink_stall_pct = 0;
        test_random_traffic(120, 1'b0);
        test_random_traffic(70, 1'b1);

        wait_idle();
        repeat (20) @(posedge i_clk);

        $display("Sent %0d raw readings over %0d calibration sets; %0d results compared.",
                 n_sent, n_cal_sets, n_checked);
        $display("%0d results fell below 20.00 C, %0d of them below -15.00 C.", n_low, n_vlow);
        if (n_errors == 0 && awaited.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
